[rtl/assert_macros.svh]
// Assertion helpers for the RTL, included by sdt_section_payload_parser.
// Every check is clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must be true at every rising clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// When the condition holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLY(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

[rtl/sdtp_pkg.sv]
// Types and constants of the service description section parser.
// Used by sdt_section_payload_parser; no dependencies.
package sdtp_pkg;

	localparam logic [7:0] SDT_TABLE_ID     = 8'h42;
	localparam logic [7:0] SERVICE_DESC_TAG = 8'h48;

	// result kinds
	localparam logic [2:0] K_NET_ID  = 3'd0;
	localparam logic [2:0] K_SERVICE = 3'd1;
	localparam logic [2:0] K_DESC    = 3'd2;
	localparam logic [2:0] K_CRC     = 3'd3;
	localparam logic [2:0] K_WRONG   = 3'd4;

	localparam logic [2:0] SERVICE_BYTES = 3'd5;
	localparam logic [2:0] CRC_BYTES     = 3'd4;

	typedef enum logic [7:0] {
		PH_IDLE     = 8'b0000_0001,
		PH_NETLO    = 8'b0000_0010,
		PH_RESERVED = 8'b0000_0100,
		PH_SERVICE  = 8'b0000_1000,
		PH_DTAG     = 8'b0001_0000,
		PH_DLEN     = 8'b0010_0000,
		PH_DBODY    = 8'b0100_0000,
		PH_CRC      = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] word_value;
		logic [15:0] service_id;
		logic        eit_schedule;
		logic        eit_present_following;
		logic [2:0]  running_status;
		logic        free_ca_mode;
		logic [11:0] loop_length;
		logic [7:0]  descriptor_tag;
		logic [8:0]  descriptor_size;
		logic        is_service_descriptor;
		logic        last;
	} result_t;

endpackage

[rtl/sdt_section_payload_parser.sv]
// Service description section payload parser: byte-serial walk of network id,
// service records, descriptor headers and the stored CRC. Uses sdtp_pkg.
// A result appears on the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle; a byte is taken whenever the result register
// is empty or being drained.
// Reset: arst_n clears the parse state to idle and empties the result register.
module sdt_section_payload_parser
	import sdtp_pkg::*;
#(
	parameter int SECTION_BYTES_MAX = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        first_byte,
	input  logic [7:0]  table_id,
	input  logic [11:0] section_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] word_value,
	output logic [15:0] service_id,
	output logic        eit_schedule,
	output logic        eit_present_following,
	output logic [2:0]  running_status,
	output logic        free_ca_mode,
	output logic [11:0] loop_length,
	output logic [7:0]  descriptor_tag,
	output logic [8:0]  descriptor_size,
	output logic        is_service_descriptor,
	output logic        last
);

	`include "assert_macros.svh"

	localparam int POS_W = $clog2(SECTION_BYTES_MAX);
	localparam logic [POS_W-1:0] OFF_MAX   = POS_W'(SECTION_BYTES_MAX - 1);
	localparam logic [POS_W-1:0] END_MAX   = POS_W'(SECTION_BYTES_MAX - 3);
	localparam logic [POS_W-1:0] OFF_FIRST = POS_W'(9);

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] byte_offset_q, byte_offset_d;
	logic [POS_W-1:0] payload_end_q, payload_end_d;
	logic [2:0]       field_cnt_q, field_cnt_d;
	logic [39:0]      svc_hdr_q, svc_hdr_d;
	logic [11:0]      loop_total_q, loop_total_d;
	logic [13:0]      loop_used_q, loop_used_d;
	logic [7:0]       desc_left_q, desc_left_d;
	logic [31:0]      word_acc_q, word_acc_d;

	result_t res_d, res_q;
	logic    res_vld_d;
	logic    out_valid_q;
	logic    in_fire;

	logic [POS_W-1:0] off_inc;
	logic             more_rec;
	phase_t           top_phase;
	logic [39:0]      hdr_shift;
	logic [31:0]      acc_shift;
	logic [8:0]       dsize;
	logic [13:0]      loop_used_sum;
	logic [2:0]       cnt_inc;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// record fields from a 5-byte service header
	function automatic result_t put_service(input logic [39:0] h);
		result_t r;
		r = '0;
		r.service_id            = h[39:24];
		r.eit_schedule          = h[17];
		r.eit_present_following = h[16];
		r.running_status        = h[15:13];
		r.free_ca_mode          = h[12];
		r.loop_length           = h[11:0];
		return r;
	endfunction

	always_comb begin
		off_inc       = (byte_offset_q < OFF_MAX) ? byte_offset_q + POS_W'(1) : byte_offset_q;
		more_rec      = ({1'b0, off_inc} + (POS_W+1)'(1)) < {1'b0, payload_end_q};
		top_phase     = more_rec ? PH_SERVICE : PH_CRC;
		hdr_shift     = {svc_hdr_q[31:0], byte_value};
		acc_shift     = {word_acc_q[23:0], byte_value};
		dsize         = {1'b0, byte_value} + 9'd2;
		loop_used_sum = loop_used_q + {5'd0, dsize};
		cnt_inc       = field_cnt_q + 3'd1;

		phase_d       = phase_q;
		byte_offset_d = byte_offset_q;
		payload_end_d = payload_end_q;
		field_cnt_d   = field_cnt_q;
		svc_hdr_d     = svc_hdr_q;
		loop_total_d  = loop_total_q;
		loop_used_d   = loop_used_q;
		desc_left_d   = desc_left_q;
		word_acc_d    = word_acc_q;
		res_d         = '0;
		res_vld_d     = 1'b0;

		if (first_byte) begin
			if (table_id != SDT_TABLE_ID) begin
				phase_d       = PH_IDLE;
				byte_offset_d = '0;
				payload_end_d = '0;
				field_cnt_d   = '0;
				res_d.kind    = K_WRONG;
				res_d.last    = 1'b1;
				res_vld_d     = 1'b1;
			end else begin
				// clamp oversized lengths
				if ({1'b0, section_length} > 13'(END_MAX))
					payload_end_d = END_MAX;
				else
					payload_end_d = POS_W'(section_length);
				byte_offset_d = OFF_FIRST;
				word_acc_d    = {24'd0, byte_value};
				field_cnt_d   = '0;
				phase_d       = PH_NETLO;
			end
		end else begin
			unique case (phase_q)
				PH_NETLO: begin
					byte_offset_d    = off_inc;
					res_d.kind       = K_NET_ID;
					res_d.word_value = {16'd0, word_acc_q[7:0], byte_value};
					res_vld_d        = 1'b1;
					phase_d          = PH_RESERVED;
				end
				PH_RESERVED: begin
					byte_offset_d = off_inc;
					field_cnt_d   = '0;
					phase_d       = top_phase;
				end
				PH_SERVICE: begin
					byte_offset_d = off_inc;
					svc_hdr_d     = hdr_shift;
					field_cnt_d   = cnt_inc;
					if (cnt_inc == SERVICE_BYTES) begin
						field_cnt_d  = '0;
						res_d        = put_service(hdr_shift);
						res_d.kind   = K_SERVICE;
						res_vld_d    = 1'b1;
						loop_total_d = hdr_shift[11:0];
						loop_used_d  = '0;
						if (hdr_shift[11:0] != 12'd0)
							phase_d = PH_DTAG;
						else
							phase_d = top_phase;
					end
				end
				PH_DTAG: begin
					byte_offset_d = off_inc;
					word_acc_d    = {24'd0, byte_value};
					phase_d       = PH_DLEN;
				end
				PH_DLEN: begin
					byte_offset_d               = off_inc;
					loop_used_d                 = loop_used_sum;
					res_d                       = put_service(svc_hdr_q);
					res_d.kind                  = K_DESC;
					res_d.descriptor_tag        = word_acc_q[7:0];
					res_d.descriptor_size       = dsize;
					res_d.is_service_descriptor = (word_acc_q[7:0] == SERVICE_DESC_TAG);
					res_vld_d                   = 1'b1;
					desc_left_d                 = byte_value;
					if (byte_value != 8'd0) begin
						phase_d = PH_DBODY;
					end else if (loop_used_sum < {2'd0, loop_total_q}) begin
						phase_d = PH_DTAG;
					end else begin
						field_cnt_d = '0;
						phase_d     = top_phase;
					end
				end
				PH_DBODY: begin
					byte_offset_d = off_inc;
					desc_left_d   = desc_left_q - 8'd1;
					if (desc_left_q == 8'd1) begin
						if (loop_used_q < {2'd0, loop_total_q}) begin
							phase_d = PH_DTAG;
						end else begin
							field_cnt_d = '0;
							phase_d     = top_phase;
						end
					end
				end
				PH_CRC: begin
					byte_offset_d = off_inc;
					word_acc_d    = acc_shift;
					field_cnt_d   = cnt_inc;
					if (cnt_inc == CRC_BYTES) begin
						res_d.kind       = K_CRC;
						res_d.word_value = acc_shift;
						res_d.last       = 1'b1;
						res_vld_d        = 1'b1;
						phase_d          = PH_IDLE;
						byte_offset_d    = '0;
						payload_end_d    = '0;
						field_cnt_d      = '0;
					end
				end
				default: begin
					// idle: stray bytes are dropped
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			byte_offset_q <= '0;
			payload_end_q <= '0;
			field_cnt_q   <= '0;
			svc_hdr_q     <= '0;
			loop_total_q  <= '0;
			loop_used_q   <= '0;
			desc_left_q   <= '0;
			word_acc_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q       <= phase_d;
				byte_offset_q <= byte_offset_d;
				payload_end_q <= payload_end_d;
				field_cnt_q   <= field_cnt_d;
				svc_hdr_q     <= svc_hdr_d;
				loop_total_q  <= loop_total_d;
				loop_used_q   <= loop_used_d;
				desc_left_q   <= desc_left_d;
				word_acc_q    <= word_acc_d;
			end
			if (in_fire && res_vld_d)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_vld_d)
			res_q <= res_d;
	end

	assign out_valid             = out_valid_q;
	assign kind                  = res_q.kind;
	assign word_value            = res_q.word_value;
	assign service_id            = res_q.service_id;
	assign eit_schedule          = res_q.eit_schedule;
	assign eit_present_following = res_q.eit_present_following;
	assign running_status        = res_q.running_status;
	assign free_ca_mode          = res_q.free_ca_mode;
	assign loop_length           = res_q.loop_length;
	assign descriptor_tag        = res_q.descriptor_tag;
	assign descriptor_size       = res_q.descriptor_size;
	assign is_service_descriptor = res_q.is_service_descriptor;
	assign last                  = res_q.last;

	`ASSERT_IMPLY(a_ready_when_empty, !out_valid_q, in_ready, "input stalled with empty output")
	`ASSERT_ALWAYS(a_offset_sat, byte_offset_q <= OFF_MAX, "byte offset past saturation")
	`ASSERT_ALWAYS(a_end_clamped, payload_end_q <= END_MAX, "payload end not clamped")
	`ASSERT_IMPLY(a_body_nonzero, phase_q == PH_DBODY, desc_left_q != 8'd0, "empty descriptor body")
	`ASSERT_IMPLY(a_last_kind, out_valid_q && res_q.last, res_q.kind == K_CRC || res_q.kind == K_WRONG, "last on wrong kind")

endmodule

[tb/sdt_section_payload_parser_tb.sv]
// Self-checking bench for sdt_section_payload_parser: random and hand-built sections,
// a bit-true parse predictor and an in-order result scoreboard.
// Depends on sdtp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module sdt_section_payload_parser_tb;
	import sdtp_pkg::*;

	localparam int SECTION_BYTES_MAX = 4096;
	localparam int CYCLE_LIMIT       = 200000;
	localparam int HOLD_CYCLES       = 250;
	localparam int RANDOM_ITEMS      = 950;

	typedef struct {
		logic [7:0]  b;
		logic        first;
		logic [7:0]  tid;
		logic [11:0] slen;
		bit          drain;
	} sec_byte_t;

	typedef enum int {
		SEC_WRONG_TABLE = 0,
		SEC_TRUNCATED   = 1,
		SEC_RANDOM_LEN  = 2,
		SEC_SKEWED_LEN  = 3,
		SEC_NOISY       = 4,
		SEC_CLEAN       = 5
	} sec_shape_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_value = '0;
	logic        first_byte = 1'b0;
	logic [7:0]  table_id = '0;
	logic [11:0] section_length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [31:0] word_value;
	logic [15:0] service_id;
	logic        eit_schedule;
	logic        eit_present_following;
	logic [2:0]  running_status;
	logic        free_ca_mode;
	logic [11:0] loop_length;
	logic [7:0]  descriptor_tag;
	logic [8:0]  descriptor_size;
	logic        is_service_descriptor;
	logic        last;

	sdt_section_payload_parser #(
		.SECTION_BYTES_MAX(SECTION_BYTES_MAX)
	) dut (.*);

	always #5 clk = ~clk;

	sec_byte_t   pending_reqs[$];
	sec_byte_t   cur_req;
	result_t     sdt_results_due[$];
	logic [7:0]  sec_body[$];
	bit          req_taken = 0;
	int          reqs_taken = 0;
	int          phase_mark = 0;
	int          mism_count = 0;
	int          cycle_cnt = 0;
	int          hold_left = 0;
	bit          hold_started = 0;

	// predictor state
	phase_t      walk_phase;
	logic [11:0] sec_pos;
	logic [11:0] sec_end;
	logic [2:0]  field_cnt;
	logic [39:0] svc_hdr;
	logic [11:0] loop_total;
	logic [13:0] loop_used;
	logic [8:0]  desc_left;
	logic [31:0] acc;

	task automatic clear_walk();
		walk_phase = PH_IDLE;
		sec_pos    = '0;
		sec_end    = '0;
		field_cnt  = '0;
		svc_hdr    = '0;
		loop_total = '0;
		loop_used  = '0;
		desc_left  = '0;
		acc        = '0;
	endtask

	task automatic step_pos();
		if (int'(sec_pos) < SECTION_BYTES_MAX - 1)
			sec_pos++;
	endtask

	// another service record, or the CRC when only its four bytes remain
	task automatic pick_next_part();
		field_cnt = '0;
		acc = '0;
		if (int'(sec_pos) + 1 < int'(sec_end)) begin
			walk_phase = PH_SERVICE;
			svc_hdr = '0;
		end else begin
			walk_phase = PH_CRC;
		end
	endtask

	task automatic end_of_descriptor();
		if (loop_used < {2'b00, loop_total})
			walk_phase = PH_DTAG;
		else
			pick_next_part();
	endtask

	function automatic result_t with_service(input result_t r);
		r.service_id            = svc_hdr[39:24];
		r.eit_schedule          = svc_hdr[17];
		r.eit_present_following = svc_hdr[16];
		r.running_status        = svc_hdr[15:13];
		r.free_ca_mode          = svc_hdr[12];
		r.loop_length           = svc_hdr[11:0];
		return r;
	endfunction

	task automatic walk_section_byte(input sec_byte_t r);
		result_t res;
		logic [8:0] dsize;
		bit emit;
		res = '0;
		emit = 0;
		if (r.first) begin
			if (r.tid != SDT_TABLE_ID) begin
				clear_walk();
				res.kind = K_WRONG;
				res.last = 1'b1;
				emit = 1;
			end else begin
				sec_end = (int'(r.slen) > SECTION_BYTES_MAX - 3) ?
					12'(SECTION_BYTES_MAX - 3) : r.slen;
				sec_pos = 12'd9;
				acc = {24'd0, r.b};
				field_cnt = '0;
				walk_phase = PH_NETLO;
			end
		end else begin
			case (walk_phase)
				PH_NETLO: begin
					step_pos();
					res.kind = K_NET_ID;
					res.word_value = {16'd0, acc[7:0], r.b};
					walk_phase = PH_RESERVED;
					emit = 1;
				end
				PH_RESERVED: begin
					step_pos();
					pick_next_part();
				end
				PH_SERVICE: begin
					step_pos();
					svc_hdr = {svc_hdr[31:0], r.b};
					field_cnt++;
					if (field_cnt == SERVICE_BYTES) begin
						field_cnt = '0;
						res.kind = K_SERVICE;
						res = with_service(res);
						loop_total = res.loop_length;
						loop_used = '0;
						end_of_descriptor();
						emit = 1;
					end
				end
				PH_DTAG: begin
					step_pos();
					acc = {24'd0, r.b};
					walk_phase = PH_DLEN;
				end
				PH_DLEN: begin
					dsize = {1'b0, r.b} + 9'd2;
					step_pos();
					loop_used = loop_used + 14'(dsize);
					res.kind = K_DESC;
					res = with_service(res);
					res.descriptor_tag = acc[7:0];
					res.descriptor_size = dsize;
					res.is_service_descriptor = (acc[7:0] == SERVICE_DESC_TAG);
					desc_left = {1'b0, r.b};
					if (desc_left != 0)
						walk_phase = PH_DBODY;
					else
						end_of_descriptor();
					emit = 1;
				end
				PH_DBODY: begin
					step_pos();
					if (desc_left != 0)
						desc_left--;
					if (desc_left == 0)
						end_of_descriptor();
				end
				PH_CRC: begin
					step_pos();
					acc = {acc[23:0], r.b};
					field_cnt++;
					if (field_cnt == CRC_BYTES) begin
						res.kind = K_CRC;
						res.word_value = acc;
						res.last = 1'b1;
						clear_walk();
						emit = 1;
					end
				end
				default: ;
			endcase
		end
		if (emit)
			sdt_results_due.insert(sdt_results_due.size(), res);
	endtask

	function automatic string show_result(input result_t r);
		return $sformatf({"kind %0d word %h sid %h eit %b/%b rs %0d ca %b loop %0d ",
			"tag %h size %0d sd %b last %b"}, r.kind, r.word_value, r.service_id,
			r.eit_schedule, r.eit_present_following, r.running_status, r.free_ca_mode,
			r.loop_length, r.descriptor_tag, r.descriptor_size, r.is_service_descriptor,
			r.last);
	endfunction

	task automatic add_req(input logic [7:0] b, input logic first, input logic [7:0] tid,
			input logic [11:0] slen);
		sec_byte_t r;
		r.b = b;
		r.first = first;
		r.tid = tid;
		r.slen = slen;
		r.drain = 0;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	// Fills sec_body with network id, reserved byte, records and CRC.
	// The long variant overruns the whole section to saturate the position.
	task automatic build_section(input bit long_sec);
		logic [7:0] descs[$];
		int nsvc, ndesc, dlen, sum;
		logic [11:0] llen;
		logic [7:0] tag;
		sec_body.delete();
		repeat (3) sec_body.insert(sec_body.size(), 8'($urandom));
		nsvc = long_sec ? 1 : $urandom_range(0, 3);
		repeat (nsvc) begin
			descs.delete();
			sum = 0;
			ndesc = long_sec ? 16 : $urandom_range(0, 3);
			repeat (ndesc) begin
				tag = ($urandom_range(0, 3) == 0) ? SERVICE_DESC_TAG : 8'($urandom);
				dlen = long_sec ? 255 : ($urandom_range(0, 15) == 0) ?
					$urandom_range(0, 255) : $urandom_range(0, 6);
				descs.insert(descs.size(), tag);
				descs.insert(descs.size(), 8'(dlen));
				repeat (dlen) descs.insert(descs.size(), 8'($urandom));
				sum += dlen + 2;
			end
			llen = long_sec ? 12'hFFF : 12'(sum);
			// loop length at odds with the descriptors actually present
			if (!long_sec && $urandom_range(0, 7) == 0)
				llen = (sum > 0 && $urandom_range(0, 1) == 1) ?
					12'(sum - int'($urandom_range(1, sum))) : 12'($urandom_range(0, 12));
			repeat (3) sec_body.insert(sec_body.size(), 8'($urandom));
			sec_body.insert(sec_body.size(), {3'($urandom), 1'($urandom), llen[11:8]});
			sec_body.insert(sec_body.size(), llen[7:0]);
			foreach (descs[i]) sec_body.insert(sec_body.size(), descs[i]);
		end
		repeat (4) sec_body.insert(sec_body.size(), 8'($urandom));
	endtask

	task automatic emit_section(input logic [7:0] tid, input logic [11:0] slen,
			input int nbytes, input bit drain);
		sec_byte_t r;
		for (int i = 0; i < nbytes; i++) begin
			r.b = sec_body[i];
			r.first = (i == 0);
			r.tid = (i == 0) ? tid : 8'($urandom);
			r.slen = (i == 0) ? slen : 12'($urandom);
			r.drain = drain && (i == 0);
			pending_reqs.insert(pending_reqs.size(), r);
		end
	endtask

	// request side: new payload at a falling edge once the previous one is taken, with random gaps and drain waits
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			req_taken = 0;
			if (pending_reqs.size() == 0
					|| (pending_reqs[0].drain && sdt_results_due.size() != 0)
					|| $urandom_range(0, 99) < ((reqs_taken < phase_mark) ? 27 :
						(reqs_taken < 2 * phase_mark) ? 60 : 0)) begin
				in_valid <= 1'b0;
			end else begin
				cur_req = pending_reqs.pop_front();
				in_valid <= 1'b1;
				byte_value <= cur_req.b;
				first_byte <= cur_req.first;
				table_id <= cur_req.tid;
				section_length <= cur_req.slen;
			end
		end
	end

	// result side: random back-pressure plus one long hold-off mid-run
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_started && reqs_taken >= phase_mark + phase_mark / 2) begin
				hold_started = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= ((reqs_taken < phase_mark) ? 60 :
					(reqs_taken < 2 * phase_mark) ? 27 : 0));
			end
		end
	end

	// results are checked before the request of this edge is predicted
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {kind, word_value, service_id, eit_schedule, eit_present_following,
					running_status, free_ca_mode, loop_length, descriptor_tag,
					descriptor_size, is_service_descriptor, last};
				if (sdt_results_due.size() == 0) begin
					mism_count++;
					if (mism_count <= 10)
						$display("unexpected result: %s", show_result(got));
				end else begin
					want = sdt_results_due.pop_front();
					if (got !== want) begin
						mism_count++;
						if (mism_count <= 10)
							$display("mismatch\n  exp %s\n  got %s",
								show_result(want), show_result(got));
					end
				end
			end
			if (in_valid && in_ready) begin
				walk_section_byte(cur_req);
				reqs_taken++;
				req_taken = 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("sdt_section_payload_parser_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int counted;
		int nb;
		int pick;
		bit mid_drain;
		logic [7:0] tid;
		logic [11:0] slen;
		sec_shape_t shape;
		clear_walk();

		// stray byte while idle, wrong table, clamped length
		add_req(8'h00, 1'b0, 8'h00, 12'h000);
		add_req(8'hFF, 1'b1, 8'hFF, 12'hFFF);
		add_req(8'h12, 1'b1, SDT_TABLE_ID, 12'hFFF);
		add_req(8'h34, 1'b0, 8'hFF, 12'hFFF);
		add_req(8'hFF, 1'b0, 8'h00, 12'h000);
		// record with all flags set, loop of two descriptors
		add_req(8'hAB, 1'b0, 8'h00, 12'h000);
		add_req(8'hCD, 1'b0, 8'h00, 12'h000);
		add_req(8'hFF, 1'b0, 8'h00, 12'h000);
		add_req(8'hF0, 1'b0, 8'h00, 12'h000);
		add_req(8'h05, 1'b0, 8'h00, 12'h000);
		add_req(SERVICE_DESC_TAG, 1'b0, 8'h00, 12'h000);
		add_req(8'h00, 1'b0, 8'h00, 12'h000);
		add_req(8'hFF, 1'b0, 8'h00, 12'h000);
		add_req(8'h01, 1'b0, 8'h00, 12'h000);
		add_req(8'h5A, 1'b0, 8'h00, 12'h000);
		// all-zero record with empty loop
		repeat (5) add_req(8'h00, 1'b0, 8'h00, 12'h000);
		// restart mid-section into a section too short for any record
		add_req(8'h00, 1'b1, SDT_TABLE_ID, 12'h000);
		add_req(8'hFF, 1'b0, 8'h00, 12'h000);
		add_req(8'h00, 1'b0, 8'h00, 12'h000);
		add_req(8'hDE, 1'b0, 8'h00, 12'h000);
		add_req(8'hAD, 1'b0, 8'h00, 12'h000);
		add_req(8'hBE, 1'b0, 8'h00, 12'h000);
		add_req(8'hEF, 1'b0, 8'h00, 12'h000);

		counted = 0;
		mid_drain = 0;
		while (counted < RANDOM_ITEMS) begin
			build_section(1'b0);
			nb = sec_body.size();
			slen = 12'(nb + 5);
			tid = SDT_TABLE_ID;
			pick = $urandom_range(0, 15);
			shape = (pick < 5) ? sec_shape_t'(pick) : SEC_CLEAN;
			case (shape)
				SEC_WRONG_TABLE: begin
					tid = 8'($urandom);
					if (tid == SDT_TABLE_ID)
						tid = ~tid;
					nb = 1;
				end
				SEC_TRUNCATED:  nb = $urandom_range(1, nb - 1);
				SEC_RANDOM_LEN: slen = 12'($urandom);
				SEC_SKEWED_LEN: slen = slen + 12'($urandom_range(0, 8)) - 12'd4;
				SEC_NOISY:
					repeat ($urandom_range(1, 3))
						add_req(8'($urandom), 1'b0, 8'($urandom), 12'($urandom));
				default: ;
			endcase
			// one section halfway, and about one in thirty at random, waits for the block to run dry
			emit_section(tid, slen, nb, (!mid_drain && counted >= RANDOM_ITEMS / 2)
				|| $urandom_range(0, 29) == 0);
			if (counted >= RANDOM_ITEMS / 2)
				mid_drain = 1;
			counted += nb;
		end
		phase_mark = pending_reqs.size() / 3;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (sdt_results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mism_count == 0 && sdt_results_due.size() == 0)
			$display("sdt_section_payload_parser_tb OK");
		else
			$display("sdt_section_payload_parser_tb NOT OK");
		$finish;
	end

endmodule
